@@ src/kscan_pkg.sv @@
// Shared types, constants and key translation for the keypad scanner.
package kscan_pkg;

    localparam logic [7:0] KEY_NONE       = 8'd254;
    localparam logic [7:0] KEY_MULTI      = 8'd255;
    localparam logic [7:0] DEBOUNCE_RESET = 8'd20;

    typedef enum logic [1:0] {
        REQ_POLL  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_FLUSH = 2'd2
    } t_req;

    typedef struct packed {
        logic       ready;
        logic [7:0] code;
    } t_kscan_res;

    function automatic logic [7:0] key_translate(input logic [7:0] k);
        logic [7:0] m;
        unique case (k[3:0])
            4'd0:    m = 8'h01;
            4'd1:    m = 8'h02;
            4'd2:    m = 8'h03;
            4'd3:    m = 8'h0C;
            4'd4:    m = 8'h04;
            4'd5:    m = 8'h05;
            4'd6:    m = 8'h06;
            4'd7:    m = 8'h0D;
            4'd8:    m = 8'h07;
            4'd9:    m = 8'h08;
            4'd10:   m = 8'h09;
            4'd11:   m = 8'h0E;
            4'd12:   m = 8'h0A;
            4'd13:   m = 8'h00;
            4'd14:   m = 8'h0B;
            default: m = 8'h0F;
        endcase
        if (k[7:4] != 4'd0) begin
            m = k;
        end
        return m;
    endfunction

endpackage

@@ src/kscan_decode.sv @@
// Decodes sampled row and column lines into a raw key code.
module kscan_decode
    import kscan_pkg::*;
(
    input  logic [3:0] i_rows_low,
    input  logic [3:0] i_cols_low,
    output logic [7:0] o_raw
);

    logic [1:0] w_row;
    logic [1:0] w_col;

    always_comb begin
        w_row = 2'd0;
        w_col = 2'd0;
        for (int i = 0; i < 4; i++) begin
            if (i_rows_low[i]) begin
                w_row = 2'(i);
            end
            if (i_cols_low[i]) begin
                w_col = 2'(i);
            end
        end
    end

    always_comb begin
        if (i_rows_low == 4'd0) begin
            o_raw = KEY_NONE;
        end else if (!$onehot(i_rows_low)) begin
            o_raw = KEY_MULTI;
        end else if (i_cols_low == 4'd0) begin
            o_raw = KEY_NONE;
        end else if (!$onehot(i_cols_low)) begin
            o_raw = KEY_MULTI;
        end else begin
            o_raw = {4'd0, w_row, w_col};
        end
    end

endmodule

@@ src/kscan_state.sv @@
// Debounce lock, current key, new-key flag and configuration register.
module kscan_state
    import kscan_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_step,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_raw,
    output t_kscan_res o_res
);

    logic [7:0] r_cycles;
    logic [7:0] r_cur;
    logic       r_new;
    logic [7:0] r_lock;
    logic [7:0] n_cur;
    logic       n_new;
    logic [7:0] n_lock;
    logic [7:0] w_code;

    always_comb begin
        n_cur  = r_cur;
        n_new  = r_new;
        n_lock = r_lock;
        w_code = KEY_NONE;
        case (i_req_type)
            REQ_POLL: begin
                if (r_lock != 8'd0) begin
                    n_lock = r_lock - 8'd1;
                end else begin
                    n_cur = i_raw;
                    if (i_raw != KEY_NONE) begin
                        n_new = 1'b1;
                    end
                end
                if (i_raw == n_cur) begin
                    n_lock = r_cycles;
                end
                w_code = i_raw;
            end
            REQ_READ: begin
                if (r_new) begin
                    n_new  = 1'b0;
                    w_code = key_translate(r_cur);
                end
            end
            REQ_FLUSH: begin
                n_new = 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign o_res.code  = w_code;
    assign o_res.ready = n_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycles <= DEBOUNCE_RESET;
            r_cur    <= 8'd0;
            r_new    <= 1'b0;
            r_lock   <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                r_cycles <= i_cfg_wdata;
            end
            if (i_step) begin
                r_cur  <= n_cur;
                r_new  <= n_new;
                r_lock <= n_lock;
            end
        end
    end

endmodule

@@ src/keypad_4x4_scan_debounce_unit.sv @@
// Top level of the 4x4 keypad scanner with debounce.
//
// Each request on the slave stream carries a request kind in s_axis_tuser
// (poll, read or flush) and the sampled active-low row and column lines in
// s_axis_tdata. Every request yields exactly one result on the master
// stream: the key code in the low byte of m_axis_tdata and the new-key flag
// above it.
// A request is held in an input register, decoded and applied to the key
// state, and the result lands in an output register. The block takes one
// request per cycle as long as the receiver keeps up.
// When the receiver stalls, the output register holds its result and the
// input register takes one more request; s_axis_tready then drops until
// the result is taken.
// The user must write the debounce length through i_cfg_we and i_cfg_wdata
// only while the block is idle; the block does not enforce this.
// Synchronous reset empties both registers, clears the key state and
// loads a debounce length of 20.
module keypad_4x4_scan_debounce_unit
    import kscan_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rows_low[3:0], cols_low[7:4]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // key_code[7:0], key_ready[8], zero[15:9]
);

    logic       r_in_valid;
    logic [1:0] r_req;
    logic [3:0] r_rows;
    logic [3:0] r_cols;
    logic       r_out_valid;
    t_kscan_res r_res;
    logic       w_step;
    logic [7:0] w_raw;
    t_kscan_res w_res;

    assign w_step        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_step;

    kscan_decode u_decode (
        .i_rows_low (r_rows),
        .i_cols_low (r_cols),
        .o_raw      (w_raw)
    );

    kscan_state u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (w_step),
        .i_req_type  (r_req),
        .i_raw       (w_raw),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_req  <= s_axis_tuser;
            r_rows <= s_axis_tdata[3:0];
            r_cols <= s_axis_tdata[7:4];
        end
        if (w_step) begin
            r_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_res.ready, r_res.code};

endmodule

@@ src/kscan_chk.sv @@
// Port-level checker for the keypad scanner, bound to the top level.
module kscan_chk
    import kscan_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled result changed.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("Block not empty after reset.");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("Requests refused without a stalled result.");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:4] == 4'd0 || m_axis_tdata[7:0] == KEY_NONE
            || m_axis_tdata[7:0] == KEY_MULTI)
        else $error("Key code out of range.");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:9] == 7'd0)
        else $error("Result padding not zero.");

endmodule

bind keypad_4x4_scan_debounce_unit kscan_chk u_kscan_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ test/tb_top.sv @@
// Self-checking testbench for the 4x4 keypad scanner with debounce.
module tb_top;
    import kscan_pkg::*;

    localparam logic [1:0] REQ_RESERVED = 2'd3;
    localparam logic [2:0] LINE_NONE    = 3'd4;
    localparam logic [2:0] LINE_MANY    = 3'd5;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // rows_low[3:0], cols_low[7:4]
    logic [1:0]  s_axis_tuser;   // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // key_code[7:0], key_ready[8], zero[15:9]

    logic [7:0] keypad_legend [16] = '{
        8'h01, 8'h02, 8'h03, 8'h0C,
        8'h04, 8'h05, 8'h06, 8'h0D,
        8'h07, 8'h08, 8'h09, 8'h0E,
        8'h0A, 8'h00, 8'h0B, 8'h0F
    };

    logic [7:0] debounce_len = DEBOUNCE_RESET;
    logic [7:0] cur_key      = 8'd0;
    logic       key_pending  = 1'b0;
    logic [7:0] lock_count   = 8'd0;

    t_kscan_res expected_results [$];
    int         n_errors       = 0;
    int         n_requests     = 0;
    int         n_results      = 0;
    int         n_cfg_writes   = 0;
    int         rx_hold_cycles = 0;
    bit         steady         = 1'b0;

    keypad_4x4_scan_debounce_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [2:0] line_pos(input logic [3:0] v);
        logic [2:0] pos;
        pos = LINE_NONE;
        if ($countones(v) > 1) begin
            pos = LINE_MANY;
        end else begin
            for (int i = 0; i < 4; i++) begin
                if (v[i]) begin
                    pos = 3'(i);
                end
            end
        end
        return pos;
    endfunction

    function automatic logic [7:0] scan_lines(input logic [3:0] rows, input logic [3:0] cols);
        logic [2:0] r;
        logic [2:0] c;
        r = line_pos(rows);
        if (r == LINE_MANY) return KEY_MULTI;
        if (r == LINE_NONE) return KEY_NONE;
        c = line_pos(cols);
        if (c == LINE_MANY) return KEY_MULTI;
        if (c == LINE_NONE) return KEY_NONE;
        return {4'd0, r[1:0], c[1:0]};
    endfunction

    function automatic t_kscan_res predict_key_request(input logic [1:0] kind,
                                                       input logic [3:0] rows,
                                                       input logic [3:0] cols);
        t_kscan_res res;
        logic [7:0] raw;
        res.code = KEY_NONE;
        case (kind)
            REQ_POLL: begin
                raw = scan_lines(rows, cols);
                if (lock_count != 8'd0) begin
                    lock_count = lock_count - 8'd1;
                end else begin
                    cur_key = raw;
                    if (raw != KEY_NONE) key_pending = 1'b1;
                end
                if (raw == cur_key) lock_count = debounce_len;
                res.code = raw;
            end
            REQ_READ: begin
                if (key_pending) begin
                    key_pending = 1'b0;
                    res.code = (cur_key < 8'd16) ? keypad_legend[cur_key[3:0]] : cur_key;
                end
            end
            REQ_FLUSH: begin
                key_pending = 1'b0;
            end
            default: ;
        endcase
        res.ready = key_pending;
        return res;
    endfunction

    always @(posedge i_clk) begin : check_results
        t_kscan_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (expected_results.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result, expected none, got code %0d ready %0b",
                         $time, m_axis_tdata[7:0], m_axis_tdata[8]);
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tdata[7:0] != want.code || m_axis_tdata[8] != want.ready
                    || m_axis_tdata[15:9] != 7'd0) begin
                    n_errors++;
                    $display({"%0t: mismatch, expected code %0d ready %0b pad 0,",
                              " got code %0d ready %0b pad %0h"},
                             $time, want.code, want.ready,
                             m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tdata[15:9]);
                end
            end
        end
    end

    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold_cycles--;
            end else begin
                m_axis_tready <= steady || ($urandom_range(0, 99) >= 21);
            end
        end
    end

    task automatic send_key_request(input logic [1:0] kind, input logic [3:0] rows,
                                    input logic [3:0] cols);
        int gap;
        if (!steady && $urandom_range(0, 99) < 13) begin
            gap = $urandom_range(1, 3);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {cols, rows};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_results.push_back(predict_key_request(kind, rows, cols));
        n_requests++;
        @(negedge i_clk);
    endtask

    task automatic drain_key_results();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_debounce(input logic [7:0] cycles);
        drain_key_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cycles;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        debounce_len = cycles;
        n_cfg_writes++;
    endtask

    task automatic test_reset_defaults();
        send_key_request(REQ_READ, 4'h0, 4'h0);
        send_key_request(REQ_FLUSH, 4'hF, 4'hF);
        send_key_request(REQ_RESERVED, 4'hA, 4'h5);
    endtask

    task automatic test_scan_decode();
        write_debounce(8'd0);
        send_key_request(REQ_POLL, 4'b0001, 4'b0001);
        send_key_request(REQ_READ, 4'h0, 4'h0);
        send_key_request(REQ_POLL, 4'b1000, 4'b1000);
        send_key_request(REQ_READ, 4'h0, 4'h0);
        send_key_request(REQ_POLL, 4'b0100, 4'b0000);
        send_key_request(REQ_READ, 4'h0, 4'h0);
        send_key_request(REQ_POLL, 4'b1111, 4'b0000);
        send_key_request(REQ_READ, 4'h0, 4'h0);
        send_key_request(REQ_POLL, 4'b0010, 4'b1010);
        send_key_request(REQ_POLL, 4'b0001, 4'b0100);
        send_key_request(REQ_POLL, 4'b0000, 4'b1000);
        send_key_request(REQ_READ, 4'h0, 4'h0);
        send_key_request(REQ_POLL, 4'b0100, 4'b0001);
        send_key_request(REQ_FLUSH, 4'h0, 4'h0);
        send_key_request(REQ_READ, 4'h0, 4'h0);
        send_key_request(REQ_RESERVED, 4'hF, 4'hF);
    endtask

    task automatic test_debounce_lock();
        write_debounce(8'd3);
        send_key_request(REQ_POLL, 4'b0010, 4'b0010);
        repeat (4) send_key_request(REQ_POLL, 4'b0010, 4'b0100);
        send_key_request(REQ_READ, 4'h0, 4'h0);
    endtask

    task automatic test_backpressure();
        write_debounce(8'd1);
        steady = 1'b1;
        rx_hold_cycles = 50;
        repeat (12) send_key_request(REQ_POLL, 4'($urandom), 4'($urandom));
        steady = 1'b0;
        drain_key_results();
    endtask

    task automatic test_random_presses(input logic [7:0] cycles, input int budget);
        int         first;
        int         pick;
        logic [3:0] row_bit;
        logic [3:0] col_bit;
        write_debounce(cycles);
        first = n_requests;
        while (n_requests - first < budget) begin
            if ($urandom_range(0, 99) < 20) begin
                send_key_request(2'($urandom_range(0, 3)), 4'($urandom), 4'($urandom));
            end else begin
                row_bit = 4'b0001 << $urandom_range(0, 3);
                col_bit = 4'b0001 << $urandom_range(0, 3);
                repeat ($urandom_range(0, 2))
                    send_key_request(REQ_POLL, 4'($urandom), 4'($urandom));
                repeat ($urandom_range(1, 6)) send_key_request(REQ_POLL, row_bit, col_bit);
                repeat ($urandom_range(0, int'(cycles) + 2)) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_key_request(REQ_POLL, row_bit, 4'h0);
                    end else begin
                        send_key_request(REQ_POLL, 4'h0, 4'($urandom));
                    end
                end
                pick = $urandom_range(0, 9);
                if (pick < 8) begin
                    send_key_request(REQ_READ, 4'($urandom), 4'($urandom));
                end else if (pick == 8) begin
                    send_key_request(REQ_FLUSH, 4'($urandom), 4'($urandom));
                end else begin
                    send_key_request(REQ_RESERVED, 4'($urandom), 4'($urandom));
                end
            end
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= 8'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        s_axis_tuser  <= REQ_POLL;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_scan_decode();
        test_debounce_lock();
        test_backpressure();
        test_random_presses(8'd0, 250);
        test_random_presses(8'd1, 250);
        test_random_presses(8'd4, 250);
        test_random_presses(8'd20, 250);
        test_random_presses(8'd255, 250);
        test_random_presses(8'($urandom_range(5, 30)), 200);
        steady = 1'b1;
        test_random_presses(8'd2, 200);
        steady = 1'b0;

        drain_key_results();
        repeat (10) @(negedge i_clk);
        $display("Covered %0d key requests and %0d results over %0d debounce settings,",
                 n_requests, n_results, n_cfg_writes);
        $display("including reserved requests, multi-key scans and a long receiver hold-off.");
        if (n_errors == 0) begin
            $display("keypad_4x4_scan_debounce_unit regression: pass");
        end else begin
            $display("keypad_4x4_scan_debounce_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #1_600_000;
        $display("Timed out with %0d results still outstanding.", expected_results.size());
        $display("keypad_4x4_scan_debounce_unit regression: fail");
        $finish;
    end

endmodule
